FILE: sv/log_spiral_arm_pixel_test_defines.svh
// ----------------------------------------------------------------------------
// Log spiral arm pixel test: assertion macros
// Property wrappers for the RTL file that carries assertions.
// ----------------------------------------------------------------------------
`ifndef LOG_SPIRAL_ARM_PIXEL_TEST_DEFINES_SVH
`define LOG_SPIRAL_ARM_PIXEL_TEST_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define LSAPT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define LSAPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/lsapt_pkg.sv
// ----------------------------------------------------------------------------
// Log spiral arm pixel test package
// Shared constants, register codes, tables and types.
// ----------------------------------------------------------------------------
`default_nettype none

package lsapt_pkg;

    localparam int DEF_COORD_BITS  = 10;
    localparam int DEF_CELL_WIDTH  = 2;
    localparam int DEF_CELL_HEIGHT = 4;
    localparam int DEF_ANGLE_BITS  = 16;

    localparam int CENTER_BITS = 10;
    localparam int RMIN_BITS   = 8;
    localparam int TPL_BITS    = 20;
    localparam int ARM_BITS    = 4;
    localparam int HW_BITS     = 15;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 20;

    localparam logic [CENTER_BITS-1:0] CENTER_COL_RST = 10'd40;
    localparam logic [CENTER_BITS-1:0] CENTER_ROW_RST = 10'd12;
    localparam logic [RMIN_BITS-1:0]   MIN_RADIUS_RST = 8'd4;
    localparam logic [TPL_BITS-1:0]    TPL_RST        = 20'd57944;
    localparam logic [ARM_BITS-1:0]    ARM_COUNT_RST  = 4'd2;
    localparam logic [HW_BITS-1:0]     ARM_HW_RST     = 15'd2294;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CENTER_COL    = 3'd0,
        CFG_CENTER_ROW    = 3'd1,
        CFG_MIN_RADIUS    = 3'd2,
        CFG_TURNS_PER_LOG = 3'd3,
        CFG_ARM_COUNT     = 3'd4,
        CFG_ARM_HALFWIDTH = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        GLYPH_DASH      = 2'd0,
        GLYPH_BACKSLASH = 2'd1,
        GLYPH_BAR       = 2'd2,
        GLYPH_SLASH     = 2'd3
    } t_glyph;

    localparam int CORDIC_STEPS = 24;
    localparam int LOG_STEPS    = 24;
    localparam int LOG_FRAC     = 24;
    localparam int MANT_BITS    = 31;
    localparam int MANT_FRAC    = 30;
    localparam int PHASE_STAGES = 5;
    localparam int P_SPLIT      = 20;
    localparam int P_SHIFT      = 21;

    localparam logic [31:0] LN2_Q32  = 32'd2977044472;
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;

    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        logic [TPL_BITS-1:0] turns_per_log;
        logic [ARM_BITS-1:0] arm_count;
        logic [HW_BITS-1:0]  arm_halfwidth;
    } t_phase_cfg;

    typedef struct packed {
        logic   on_arm;
        t_glyph glyph;
    } t_result;

endpackage

`default_nettype wire

FILE: sv/lsapt_pix_if.sv
// ----------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel that carries one pixel coordinate per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsapt_pix_if #(
    parameter int COORD_BITS = lsapt_pkg::DEF_COORD_BITS
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_col;
    logic [COORD_BITS-1:0] pixel_row;

    modport source (output valid, output pixel_col, output pixel_row, input ready);
    modport sink   (input valid, input pixel_col, input pixel_row, output ready);
endinterface

`default_nettype wire

FILE: sv/lsapt_res_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one arm test result per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsapt_res_if;
    logic       valid;
    logic       ready;
    logic       on_arm;
    logic [1:0] glyph;

    modport source (output valid, output on_arm, output glyph, input ready);
    modport sink   (input valid, input on_arm, input glyph, output ready);
endinterface

`default_nettype wire

FILE: sv/log_spiral_arm_pixel_test.sv
// Throughput: one item per cycle unless the output buffer is full and o_res
// is not ready; depth is set by the 24 CORDIC stages and the 26-stage log2
// squaring pipeline that run side by side.
// A two-entry output buffer keeps input ready while one result waits.
// Reset (synchronous, active low) restores the configuration defaults and
// clears all valid bits and the output buffer.
// ----------------------------------------------------------------------------
// Log spiral arm pixel test
// Classifies each pixel as on or off a multi-arm log spiral, with glyph.
// ----------------------------------------------------------------------------
`default_nettype none

`include "log_spiral_arm_pixel_test_defines.svh"

module log_spiral_arm_pixel_test #(
    parameter int COORD_BITS  = lsapt_pkg::DEF_COORD_BITS,
    parameter int CELL_WIDTH  = lsapt_pkg::DEF_CELL_WIDTH,
    parameter int CELL_HEIGHT = lsapt_pkg::DEF_CELL_HEIGHT,
    parameter int ANGLE_BITS  = lsapt_pkg::DEF_ANGLE_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [lsapt_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [lsapt_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    lsapt_pix_if.sink                                i_pix,
    lsapt_res_if.source                              o_res
);
    import lsapt_pkg::*;

    localparam int CELL_MAX = (CELL_WIDTH > CELL_HEIGHT) ? CELL_WIDTH : CELL_HEIGHT;
    localparam int DX_BITS  = COORD_BITS + 1 + $clog2(CELL_MAX);
    localparam int R2_BITS  = 2 * DX_BITS;
    localparam int RM2_BITS = 2 * RMIN_BITS;
    localparam int CMP_BITS = (R2_BITS > RM2_BITS) ? R2_BITS : RM2_BITS;
    localparam int LOG_BITS = $clog2(R2_BITS) + LOG_FRAC;
    localparam int CC_BITS  = (COORD_BITS < CENTER_BITS) ? COORD_BITS : CENTER_BITS;

    localparam int S_DX       = 1;
    localparam int S_R2       = S_DX + 2;
    localparam int S_GE       = S_R2 + 1;
    localparam int S_ANGLE    = S_DX + CORDIC_STEPS + 2;
    localparam int S_LOG      = S_R2 + LOG_STEPS + 2;
    localparam int PIPE_DEPTH = S_LOG + PHASE_STAGES;
    localparam int TH_DLY     = S_LOG - S_ANGLE;
    localparam int GE_DLY     = S_LOG - S_GE + 1;

    logic [CENTER_BITS-1:0] r_center_col, r_center_row;
    logic [RMIN_BITS-1:0]   r_min_radius;
    t_phase_cfg             r_pcfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_col         <= CENTER_COL_RST;
            r_center_row         <= CENTER_ROW_RST;
            r_min_radius         <= MIN_RADIUS_RST;
            r_pcfg.turns_per_log <= TPL_RST;
            r_pcfg.arm_count     <= ARM_COUNT_RST;
            r_pcfg.arm_halfwidth <= ARM_HW_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CENTER_COL:    r_center_col <= i_cfg_data[CENTER_BITS-1:0];
                CFG_CENTER_ROW:    r_center_row <= i_cfg_data[CENTER_BITS-1:0];
                CFG_MIN_RADIUS:    r_min_radius <= i_cfg_data[RMIN_BITS-1:0];
                CFG_TURNS_PER_LOG: r_pcfg.turns_per_log <= i_cfg_data[TPL_BITS-1:0];
                CFG_ARM_COUNT:     r_pcfg.arm_count <= i_cfg_data[ARM_BITS-1:0];
                CFG_ARM_HALFWIDTH: r_pcfg.arm_halfwidth <= i_cfg_data[HW_BITS-1:0];
                default: ;
            endcase
        end
    end

    logic adv;
    logic [PIPE_DEPTH:1] r_vld;
    logic r_b0_vld, r_b1_vld;
    t_result r_b0, r_b1;

    assign adv         = !r_b1_vld || o_res.ready;
    assign i_pix.ready = adv;

    logic [COORD_BITS-1:0]        ccol, crow;
    logic signed [COORD_BITS:0]   dcol, drow;
    logic signed [DX_BITS-1:0]    n_dx, n_dy, r_dx, r_dy;
    logic signed [R2_BITS-1:0]    dxw, dyw;
    logic [R2_BITS-1:0]           r_sqx, r_sqy, r_r2;
    logic [RMIN_BITS-1:0]         rmin;
    logic [RM2_BITS-1:0]          r_rm2, r_rm2b;

    assign ccol = COORD_BITS'(r_center_col[CC_BITS-1:0]);
    assign crow = COORD_BITS'(r_center_row[CC_BITS-1:0]);
    assign dcol = $signed({1'b0, i_pix.pixel_col}) - $signed({1'b0, ccol});
    assign drow = $signed({1'b0, i_pix.pixel_row}) - $signed({1'b0, crow});
    assign n_dx = DX_BITS'(DX_BITS'(dcol) * DX_BITS'(CELL_WIDTH));
    assign n_dy = DX_BITS'(DX_BITS'(drow) * DX_BITS'(CELL_HEIGHT));
    assign dxw  = R2_BITS'(r_dx);
    assign dyw  = R2_BITS'(r_dy);
    assign rmin = (r_min_radius == '0) ? RMIN_BITS'(1) : r_min_radius;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dx   <= n_dx;
            r_dy   <= n_dy;
            r_sqx  <= dxw * dxw;
            r_sqy  <= dyw * dyw;
            r_rm2  <= RM2_BITS'(rmin) * RM2_BITS'(rmin);
            r_r2   <= r_sqx + r_sqy;
            r_rm2b <= r_rm2;
        end
    end

    logic [31:0] theta;
    t_glyph      glyph;
    logic [LOG_BITS-1:0] la, lb;

    lsapt_cordic #(
        .DX_BITS    (DX_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_dx    (r_dx),
        .i_dy    (r_dy),
        .o_theta (theta),
        .o_glyph (glyph)
    );

    lsapt_log2 #(
        .IN_BITS  (R2_BITS),
        .OUT_BITS (LOG_BITS)
    ) u_log_r2 (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_x   (r_r2),
        .o_log (la)
    );

    lsapt_log2 #(
        .IN_BITS  (RM2_BITS),
        .OUT_BITS (LOG_BITS)
    ) u_log_rm2 (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_x   (r_rm2b),
        .o_log (lb)
    );

    logic [31:0] r_th_dly [TH_DLY];
    t_glyph      r_gl_dly [TH_DLY];
    logic        r_ge_dly [GE_DLY];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_th_dly[0] <= theta;
            r_gl_dly[0] <= glyph;
            for (int k = 1; k < TH_DLY; k++) begin
                r_th_dly[k] <= r_th_dly[k-1];
                r_gl_dly[k] <= r_gl_dly[k-1];
            end
            r_ge_dly[0] <= CMP_BITS'(r_r2) >= CMP_BITS'(r_rm2b);
            for (int k = 1; k < GE_DLY; k++) begin
                r_ge_dly[k] <= r_ge_dly[k-1];
            end
        end
    end

    logic    res_on;
    t_glyph  res_gl;
    t_result res;

    lsapt_phase #(
        .LOG_BITS (LOG_BITS)
    ) u_phase (
        .i_clk    (i_clk),
        .i_en     (adv),
        .i_la     (la),
        .i_lb     (lb),
        .i_theta  (r_th_dly[TH_DLY-1]),
        .i_glyph  (r_gl_dly[TH_DLY-1]),
        .i_ge     (r_ge_dly[GE_DLY-1]),
        .i_cfg    (r_pcfg),
        .o_on_arm (res_on),
        .o_glyph  (res_gl)
    );

    assign res = '{on_arm: res_on, glyph: res_gl};

    logic push, pop;

    assign push = adv && r_vld[PIPE_DEPTH];
    assign pop  = r_b0_vld && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_b0_vld <= 1'b0;
            r_b1_vld <= 1'b0;
        end else begin
            if (adv) r_vld <= {r_vld[PIPE_DEPTH-1:1], i_pix.valid};
            if (pop) begin
                if (r_b1_vld) begin
                    r_b1_vld <= push;
                end else begin
                    r_b0_vld <= push;
                end
            end else if (!r_b0_vld) begin
                r_b0_vld <= push;
            end else if (push) begin
                r_b1_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_b1_vld) begin
                r_b0 <= r_b1;
                r_b1 <= res;
            end else begin
                r_b0 <= res;
            end
        end else if (!r_b0_vld) begin
            r_b0 <= res;
        end else if (push) begin
            r_b1 <= res;
        end
    end

    assign o_res.valid  = r_b0_vld;
    assign o_res.on_arm = r_b0.on_arm;
    assign o_res.glyph  = r_b0.glyph;

    `LSAPT_ASSERT_NOW(a_buf_order, r_b1_vld, r_b0_vld, "second buffer slot full ahead of head")
    `LSAPT_ASSERT_NEXT(a_stall_hold, !adv, $stable(r_vld), "pipeline moved during stall")
    `LSAPT_ASSERT_NEXT(a_enter, i_pix.valid && i_pix.ready, r_vld[1], "accepted item not in stage one")

endmodule

`default_nettype wire

FILE: sv/lsapt_cordic.sv
// ----------------------------------------------------------------------------
// CORDIC angle pipeline
// Vectoring CORDIC, one iteration per stage, angle in turns with glyph.
// ----------------------------------------------------------------------------
`default_nettype none

module lsapt_cordic #(
    parameter int DX_BITS    = 16,
    parameter int ANGLE_BITS = lsapt_pkg::DEF_ANGLE_BITS
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic signed [DX_BITS-1:0] i_dx,
    input  wire logic signed [DX_BITS-1:0] i_dy,
    output logic                    [31:0] o_theta,
    output lsapt_pkg::t_glyph              o_glyph
);
    import lsapt_pkg::*;

    localparam int XW = DX_BITS + 18;
    localparam logic [31:0] RND       = 32'd1 << (31 - ANGLE_BITS);
    localparam logic [31:0] KEEP_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

    logic signed [XW-1:0] r_x    [CORDIC_STEPS+1];
    logic signed [XW-1:0] r_y    [CORDIC_STEPS+1];
    logic        [31:0]   r_z    [CORDIC_STEPS+1];
    logic                 r_zero [CORDIC_STEPS+1];

    logic signed [XW-1:0] x0, y0;
    logic [31:0]          z_fin, n_theta;
    logic [30:0]          half;
    t_glyph               n_glyph;

    assign x0 = $signed({{2{i_dx[DX_BITS-1]}}, i_dx, 16'b0});
    assign y0 = $signed({{2{i_dy[DX_BITS-1]}}, i_dy, 16'b0});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_dx == '0) && (i_dy == '0);
            if (i_dx[DX_BITS-1]) begin
                r_x[0] <= -x0;
                r_y[0] <= -y0;
                r_z[0] <= HALF_TURN;
            end else begin
                r_x[0] <= x0;
                r_y[0] <= y0;
                r_z[0] <= '0;
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                r_zero[i+1] <= r_zero[i];
                if (r_y[i] > 0) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + ATAN_TURNS[i];
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - ATAN_TURNS[i];
                end
            end
        end
    end

    assign z_fin   = r_zero[CORDIC_STEPS] ? '0 : r_z[CORDIC_STEPS];
    assign n_theta = (z_fin + RND) & KEEP_MASK;
    assign half    = n_theta[30:0];

    always_comb begin
        priority if (half < 31'h1000_0000 || half >= 31'h7000_0000) n_glyph = GLYPH_DASH;
        else if (half < 31'h3000_0000) n_glyph = GLYPH_BACKSLASH;
        else if (half < 31'h5000_0000) n_glyph = GLYPH_BAR;
        else n_glyph = GLYPH_SLASH;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_theta <= n_theta;
            o_glyph <= n_glyph;
        end
    end

endmodule

`default_nettype wire

FILE: sv/lsapt_log2.sv
// ----------------------------------------------------------------------------
// Log2 pipeline
// Leading-one search, normalize, then one squaring step per stage, Q.24 out.
// ----------------------------------------------------------------------------
`default_nettype none

module lsapt_log2 #(
    parameter int IN_BITS  = 32,
    parameter int OUT_BITS = 29
) (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire logic [IN_BITS-1:0]  i_x,
    output logic      [OUT_BITS-1:0] o_log
);
    import lsapt_pkg::*;

    localparam int E_BITS  = $clog2(IN_BITS);
    localparam int EO_BITS = OUT_BITS - LOG_FRAC;
    localparam int SQ_BITS = 2 * MANT_BITS;

    logic [IN_BITS-1:0]   r_x;
    logic [E_BITS-1:0]    r_e0;
    logic [E_BITS-1:0]    r_e [LOG_STEPS+1];
    logic [MANT_BITS-1:0] r_m [LOG_STEPS+1];
    logic [LOG_FRAC-1:0]  r_f [LOG_STEPS+1];

    logic [E_BITS-1:0]        n_e;
    logic [IN_BITS+29:0]      sh;
    logic [SQ_BITS-1:0]       sq_p [LOG_STEPS];
    logic [31:0]              sq_t [LOG_STEPS];

    always_comb begin
        n_e = '0;
        for (int k = 0; k < IN_BITS; k++) begin
            if (i_x[k]) n_e = E_BITS'(k);
        end
    end

    assign sh = {r_x, 30'b0} >> r_e0;

    for (genvar k = 0; k < LOG_STEPS; k++) begin : g_sq
        assign sq_p[k] = SQ_BITS'(r_m[k]) * SQ_BITS'(r_m[k]);
        assign sq_t[k] = sq_p[k][SQ_BITS-1:MANT_FRAC];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x  <= i_x;
            r_e0 <= n_e;
            r_m[0] <= sh[MANT_BITS-1:0];
            r_e[0] <= r_e0;
            r_f[0] <= '0;
            for (int k = 0; k < LOG_STEPS; k++) begin
                r_e[k+1] <= r_e[k];
                if (sq_t[k][31]) begin
                    r_m[k+1] <= sq_t[k][31:1];
                    r_f[k+1] <= {r_f[k][LOG_FRAC-2:0], 1'b1};
                end else begin
                    r_m[k+1] <= sq_t[k][30:0];
                    r_f[k+1] <= {r_f[k][LOG_FRAC-2:0], 1'b0};
                end
            end
        end
    end

    assign o_log = {EO_BITS'(r_e[LOG_STEPS]), r_f[LOG_STEPS]};

endmodule

`default_nettype wire

FILE: sv/lsapt_phase.sv
// ----------------------------------------------------------------------------
// Arm phase pipeline
// Predicted angle from the log ratio, arm phase wrap and half-width test.
// ----------------------------------------------------------------------------
`default_nettype none

module lsapt_phase #(
    parameter int LOG_BITS = 29
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic [LOG_BITS-1:0]   i_la,
    input  wire logic [LOG_BITS-1:0]   i_lb,
    input  wire logic [31:0]           i_theta,
    input  wire lsapt_pkg::t_glyph     i_glyph,
    input  wire logic                  i_ge,
    input  wire lsapt_pkg::t_phase_cfg i_cfg,
    output logic                       o_on_arm,
    output lsapt_pkg::t_glyph          o_glyph
);
    import lsapt_pkg::*;

    localparam int A_BITS   = LOG_BITS + TPL_BITS;
    localparam int HI_BITS  = LOG_BITS + 32;
    localparam int LO_BITS  = P_SPLIT + 32;
    localparam int SUM_BITS = LOG_BITS + 33;

    logic [LOG_BITS-1:0] r_d;
    logic [A_BITS-1:0]   r_a;
    logic [HI_BITS-1:0]  r_phi;
    logic [LO_BITS-1:0]  r_plo;
    logic [31:0]         r_th_d, r_th_e, r_th_f;
    logic [31:0]         r_diff, r_ph;
    logic                r_ge [PHASE_STAGES];
    t_glyph              r_gl [PHASE_STAGES];

    logic [SUM_BITS-1:0] sum;
    logic [31:0]         p;
    logic [32:0]         h, lim;

    assign sum = SUM_BITS'(r_phi) + SUM_BITS'(r_plo >> P_SPLIT);
    assign p   = sum[P_SHIFT+31:P_SHIFT];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d    <= (i_la > i_lb) ? (i_la - i_lb) : '0;
            r_th_d <= i_theta;
            r_a    <= A_BITS'(r_d) * A_BITS'(i_cfg.turns_per_log);
            r_th_e <= r_th_d;
            r_phi  <= HI_BITS'(r_a[A_BITS-1:P_SPLIT]) * HI_BITS'(LN2_Q32);
            r_plo  <= LO_BITS'(r_a[P_SPLIT-1:0]) * LO_BITS'(LN2_Q32);
            r_th_f <= r_th_e;
            r_diff <= r_th_f - p;
            r_ph   <= r_diff * 32'(i_cfg.arm_count);
            r_ge[0] <= i_ge;
            r_gl[0] <= i_glyph;
            for (int k = 1; k < PHASE_STAGES; k++) begin
                r_ge[k] <= r_ge[k-1];
                r_gl[k] <= r_gl[k-1];
            end
        end
    end

    assign h   = 33'(i_cfg.arm_halfwidth) << 16;
    assign lim = 33'h1_0000_0000 - h;

    assign o_on_arm = r_ge[PHASE_STAGES-1] && (({1'b0, r_ph} < h) || ({1'b0, r_ph} > lim));
    assign o_glyph  = r_gl[PHASE_STAGES-1];

endmodule

`default_nettype wire

FILE: verif/tb_log_spiral_arm_pixel_test.sv
// ----------------------------------------------------------------------------
// Log spiral arm pixel test bench
// Streams pixel coordinates through the block over several register settings
// with random gaps and stalls on both channels, and checks each result
// against a table entry or an in-bench spiral membership predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_log_spiral_arm_pixel_test;
    import lsapt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE = 3'd6;
    localparam int PIPE_CYCLES = 40;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_PER_PHASE = 142;
    localparam int NUM_PHASES = 8;

    typedef struct {
        logic [9:0] col;
        logic [9:0] row;
        bit         typed;
        t_result    res;
    } t_pix_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    lsapt_pix_if pix ();
    lsapt_res_if res ();

    log_spiral_arm_pixel_test dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix),
        .o_res      (res)
    );

    always #5 i_clk = ~i_clk;

    logic [9:0]  cur_col, cur_row;
    logic [7:0]  cur_rmin;
    logic [19:0] cur_tpl;
    logic [3:0]  cur_arms;
    logic [14:0] cur_hw;

    t_result arm_q[$];
    int      fails = 0;
    int      cycles = 0;
    int      rcv_count = 0;
    bit      send_steady = 1'b0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic longint log2_q24(longint x);
        longint e, m, f;
        e = 0;
        f = 0;
        while (e < 63 && (x >> (e + 1)) != 0) e++;
        m = (e <= 30) ? (x << (30 - e)) : (x >> (e - 30));
        for (int k = 0; k < LOG_STEPS; k++) begin
            m = (m * m) >> 30;
            f = f << 1;
            if (m >= 64'h8000_0000) begin
                m = m >> 1;
                f = f | 1;
            end
        end
        return (e << 24) | f;
    endfunction

    function automatic t_result spiral_predict(logic [9:0] col, logic [9:0] row);
        longint dx, dy, x, y, xs, ys, r2, rmin, rm2, la, lb, d, a, hi, lo, p, ph, h;
        logic [31:0] z, theta, half, diff;
        t_result r;
        dx = (longint'(col) - longint'(cur_col)) * DEF_CELL_WIDTH;
        dy = (longint'(row) - longint'(cur_row)) * DEF_CELL_HEIGHT;
        r2 = dx * dx + dy * dy;
        rmin = (cur_rmin == 0) ? 1 : longint'(cur_rmin);
        rm2 = rmin * rmin;
        z = '0;
        if (dx != 0 || dy != 0) begin
            x = dx * 65536;
            y = dy * 65536;
            if (x < 0) begin
                x = -x;
                y = -y;
                z = HALF_TURN;
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ATAN_TURNS[i];
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ATAN_TURNS[i];
                end
            end
        end
        theta = 32'(((longint'(z) + 32768) >> 16) & 16'hFFFF) << 16;
        half = theta & 32'h7FFF_FFFF;
        if (half < 32'h1000_0000 || half >= 32'h7000_0000) r.glyph = GLYPH_DASH;
        else if (half < 32'h3000_0000) r.glyph = GLYPH_BACKSLASH;
        else if (half < 32'h5000_0000) r.glyph = GLYPH_BAR;
        else r.glyph = GLYPH_SLASH;
        r.on_arm = 1'b0;
        if (r2 >= rm2) begin
            la = log2_q24(r2);
            lb = log2_q24(rm2);
            d = (la > lb) ? la - lb : 0;
            a = d * longint'(cur_tpl);
            hi = a >> 20;
            lo = a & 20'hFFFFF;
            p = (hi * longint'(LN2_Q32) + ((lo * longint'(LN2_Q32)) >> 20)) >> 21;
            diff = theta - p[31:0];
            ph = (longint'(cur_arms) * longint'(diff)) & 32'hFFFF_FFFF;
            h = longint'(cur_hw) << 16;
            r.on_arm = (ph < h) || (ph > (64'd1 << 32) - h);
        end
        return r;
    endfunction

    task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, logic [19:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_CENTER_COL:    cur_col  = data[9:0];
            CFG_CENTER_ROW:    cur_row  = data[9:0];
            CFG_MIN_RADIUS:    cur_rmin = data[7:0];
            CFG_TURNS_PER_LOG: cur_tpl  = data[19:0];
            CFG_ARM_COUNT:     cur_arms = data[3:0];
            CFG_ARM_HALFWIDTH: cur_hw   = data[14:0];
            default: ;
        endcase
    endtask

    task automatic cfg_apply(logic [19:0] c, logic [19:0] r, logic [19:0] m,
                             logic [19:0] t, logic [19:0] n, logic [19:0] w);
        cfg_write(CFG_CENTER_COL, c);
        cfg_write(CFG_CENTER_ROW, r);
        cfg_write(CFG_MIN_RADIUS, m);
        cfg_write(CFG_TURNS_PER_LOG, t);
        cfg_write(CFG_ARM_COUNT, n);
        cfg_write(CFG_ARM_HALFWIDTH, w);
        cfg_write(CFG_IDX_SPARE, $urandom);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_pixel(logic [9:0] col, logic [9:0] row, bit typed, t_result exp_r);
        int gap;
        gap = send_steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix.valid     <= 1'b1;
        pix.pixel_col <= col;
        pix.pixel_row <= row;
        do @(posedge i_clk); while (!pix.ready);
        arm_q.push_back(typed ? exp_r : spiral_predict(col, row));
    endtask

    function automatic logic [9:0] pick_coord(logic [9:0] centre);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5) return centre + 10'($urandom_range(0, 64)) - 10'd32;
        if (sel == 5) return ($urandom_range(0, 1) != 0) ? 10'h3FF : 10'h000;
        return 10'($urandom);
    endfunction

    task automatic drain_wait();
        pix.valid <= 1'b0;
        while (arm_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_CYCLES) @(posedge i_clk);
    endtask

    t_pix_row pix_table[] = '{
        '{10'd40,   10'd12,   1'b1, '{1'b0, GLYPH_DASH}},
        '{10'd41,   10'd12,   1'b1, '{1'b0, GLYPH_DASH}},
        '{10'd40,   10'd13,   1'b1, '{1'b0, GLYPH_BAR}},
        '{10'd40,   10'd11,   1'b1, '{1'b0, GLYPH_BAR}},
        '{10'd0,    10'd0,    1'b0, '{1'b0, GLYPH_DASH}},
        '{10'h3FF,  10'h3FF,  1'b0, '{1'b0, GLYPH_DASH}},
        '{10'd0,    10'h3FF,  1'b0, '{1'b0, GLYPH_DASH}},
        '{10'h3FF,  10'd0,    1'b0, '{1'b0, GLYPH_DASH}},
        '{10'h2AA,  10'h155,  1'b0, '{1'b0, GLYPH_DASH}},
        '{10'h155,  10'h2AA,  1'b0, '{1'b0, GLYPH_DASH}},
        '{10'd39,   10'd12,   1'b0, '{1'b0, GLYPH_DASH}},
        '{10'd42,   10'd12,   1'b0, '{1'b0, GLYPH_DASH}},
        '{10'd44,   10'd14,   1'b0, '{1'b0, GLYPH_DASH}},
        '{10'd36,   10'd10,   1'b0, '{1'b0, GLYPH_DASH}},
        '{10'd50,   10'd20,   1'b0, '{1'b0, GLYPH_DASH}},
        '{10'd30,   10'd5,    1'b0, '{1'b0, GLYPH_DASH}},
        '{10'd60,   10'd12,   1'b0, '{1'b0, GLYPH_DASH}},
        '{10'd40,   10'd30,   1'b0, '{1'b0, GLYPH_DASH}}
    };

    initial begin
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        pix.valid     <= 1'b0;
        pix.pixel_col <= '0;
        pix.pixel_row <= '0;
        cur_col  = CENTER_COL_RST;
        cur_row  = CENTER_ROW_RST;
        cur_rmin = MIN_RADIUS_RST;
        cur_tpl  = TPL_RST;
        cur_arms = ARM_COUNT_RST;
        cur_hw   = ARM_HW_RST;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (pix_table[k])
            send_pixel(pix_table[k].col, pix_table[k].row, pix_table[k].typed,
                       pix_table[k].res);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) begin
                drain_wait();
                case (ph)
                    1: cfg_apply(0, 0, 1, 1, 1, 20'h7FFF);
                    2: cfg_apply(20'h3FF, 20'h3FF, 20'hFF, 20'hFFFFF, 8, 0);
                    3: cfg_apply(512, 512, 0, 57944, 0, 2294);
                    4: cfg_apply(500, 300, 3, 20000, 15, 4000);
                    default: cfg_apply($urandom, $urandom, $urandom, $urandom,
                                       $urandom, $urandom);
                endcase
            end
            send_steady = (ph % 3 == 1);
            for (int k = 0; k < RAND_PER_PHASE; k++)
                send_pixel(pick_coord(cur_col), pick_coord(cur_row), 1'b0,
                           '{1'b0, GLYPH_DASH});
        end
        drain_wait();
        if (fails == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        int gap;
        t_result want;
        res.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rcv_count == 400) gap = 250;
            else if ((rcv_count / 100) % 4 == 2) gap = 0;
            else gap = $urandom_range(0, 6);
            if (gap > 0) begin
                res.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res.ready <= 1'b1;
            do @(posedge i_clk); while (!res.valid);
            rcv_count++;
            if (arm_q.size() == 0) begin
                $error("result with nothing pending: on_arm=%0d glyph=%0d",
                       res.on_arm, res.glyph);
                fails++;
            end else begin
                want = arm_q.pop_front();
                if (res.on_arm !== want.on_arm) begin
                    $error("on_arm: expected %0d, got %0d", want.on_arm, res.on_arm);
                    fails++;
                end
                if (res.glyph !== want.glyph) begin
                    $error("glyph: expected %0d, got %0d", want.glyph, res.glyph);
                    fails++;
                end
            end
        end
    end

endmodule

`default_nettype wire
